// File: design/bli_pkg.sv
// Shared types and constants of the bar level interpolator.
// Used by bli_div, bli_ctrl, bli_dpath and bar_level_interpolator.
`timescale 1ns / 1ps
`default_nettype none

package bli_pkg;

  localparam int NUM_POINTS       = 6;
  localparam int DEF_MAX_TICKS    = 6;
  localparam int DEF_MAX_SEGMENTS = 32;

  localparam int VAL_W     = 16;
  localparam int SEG_W     = 6;
  localparam int POINT_W   = 22;
  localparam int CFG_W     = 22;
  localparam int CIDX_W    = 3;
  localparam int TCNT_W    = 3;
  localparam int TIDX_W    = 3;
  localparam int IDX_W     = 5;
  localparam int KIND_W    = 2;
  localparam int PART_W    = 8;
  localparam int LEVEL_W   = 7;
  localparam int DIV_W     = 24;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = 8;
  localparam int STEPS_W   = 4;
  localparam int FRAC_STEPS = 252;

  // A square of at most 251 * 251 times SQ_RECIP, shifted right by SQ_SHIFT,
  // equals the square divided by FRAC_STEPS.
  localparam int SQ_RECIP  = 66577;
  localparam int SQ_SHIFT  = 24;

  localparam logic [STEPS_W-1:0] STEPS_WHOLE = 4'd6;
  localparam logic [STEPS_W-1:0] STEPS_FRAC  = 4'd8;

  localparam logic [CIDX_W-1:0] REG_TICK_COUNT    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SEGMENT_COUNT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TICK_POINT_A  = 3'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FULL    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_OFF     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIV_WHOLE,
    DIV_FRAC
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_D1GO,
    S_D1W,
    S_D2GO,
    S_D2W,
    S_SQUARE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     load_input;
    logic     search_step;
    logic     set_below;
    logic     set_above;
    logic     take_pair;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_whole;
    logic     take_frac;
    logic     take_part;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic x_zero;
    logic at_end;
    logic below_tick;
    logic div_busy;
    logic out_free;
    logic last_index;
  } status_t;

endpackage

`default_nettype wire

// File: design/bli_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bli_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module bli_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bli_pkg::DIV_W-1:0]     dividend,
  input  wire logic [bli_pkg::DEN_W-1:0]     divisor,
  input  wire logic [bli_pkg::STEPS_W-1:0]   steps,
  output      logic                          busy,
  output      logic [bli_pkg::QUO_W-1:0]     quotient,
  output      logic [bli_pkg::DEN_W-1:0]     remainder
);

  logic [bli_pkg::DIV_W-1:0]   low;
  logic [bli_pkg::DEN_W-1:0]   dsor;
  logic [bli_pkg::STEPS_W-1:0] count;
  logic [bli_pkg::DIV_W-1:0]   high_part;
  logic [bli_pkg::DEN_W+1:0]   diff;
  logic                        ge;

  assign high_part = dividend >> steps;
  assign diff = {1'b0, remainder, low[bli_pkg::DIV_W-1]} - {2'b00, dsor};
  assign ge   = !diff[bli_pkg::DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= high_part[bli_pkg::DEN_W-1:0];
      low       <= dividend << (5'(bli_pkg::DIV_W) - 5'(steps));
      dsor      <= divisor;
      quotient  <= '0;
    end else if (busy) begin
      remainder <= ge ? diff[bli_pkg::DEN_W-1:0]
                      : {remainder[bli_pkg::DEN_W-2:0], low[bli_pkg::DIV_W-1]};
      low       <= {low[bli_pkg::DIV_W-2:0], 1'b0};
      quotient  <= {quotient[bli_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: design/bli_ctrl.sv
// Controller state machine: tick search, division sequence and result output.
// Depends on bli_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bli_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire bli_pkg::status_t sts,
  output      bli_pkg::cmd_t    cmd
);

  bli_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = bli_pkg::DIV_WHOLE;
    in_stall   = (state != bli_pkg::S_IDLE);
    unique case (state)
      bli_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          state_next     = bli_pkg::S_SEARCH;
        end
      end
      bli_pkg::S_SEARCH: begin
        priority if (sts.x_zero && (sts.at_end || sts.below_tick)) begin
          cmd.set_below = 1'b1;
          state_next    = bli_pkg::S_EMIT;
        end else if (sts.at_end) begin
          cmd.set_above = 1'b1;
          state_next    = bli_pkg::S_EMIT;
        end else if (sts.below_tick) begin
          cmd.take_pair = 1'b1;
          state_next    = bli_pkg::S_MUL;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      bli_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bli_pkg::S_D1GO;
      end
      bli_pkg::S_D1GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bli_pkg::DIV_WHOLE;
        state_next    = bli_pkg::S_D1W;
      end
      bli_pkg::S_D1W: begin
        if (!sts.div_busy) begin
          cmd.take_whole = 1'b1;
          state_next     = bli_pkg::S_D2GO;
        end
      end
      bli_pkg::S_D2GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bli_pkg::DIV_FRAC;
        state_next    = bli_pkg::S_D2W;
      end
      bli_pkg::S_D2W: begin
        if (!sts.div_busy) begin
          cmd.take_frac = 1'b1;
          state_next    = bli_pkg::S_SQUARE;
        end
      end
      bli_pkg::S_SQUARE: begin
        cmd.take_part = 1'b1;
        state_next    = bli_pkg::S_EMIT;
      end
      bli_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_index) begin
            state_next = bli_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = bli_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/bli_dpath.sv
// Datapath: configuration registers, tick table search, interpolation
// arithmetic and the result register. Depends on bli_pkg and bli_div.
`timescale 1ns / 1ps
`default_nettype none

module bli_dpath #(
  parameter int MAX_TICKS    = bli_pkg::DEF_MAX_TICKS,
  parameter int MAX_SEGMENTS = bli_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [bli_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [bli_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic signed [bli_pkg::VAL_W-1:0] level_value,
  input  wire bli_pkg::cmd_t                cmd,
  output      bli_pkg::status_t             sts,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [bli_pkg::IDX_W-1:0]    segment_index,
  output      logic [bli_pkg::KIND_W-1:0]   segment_kind,
  output      logic [bli_pkg::PART_W-1:0]   partial_level,
  output      logic                         last_segment
);

  logic [bli_pkg::TCNT_W-1:0]  tick_count;
  logic [bli_pkg::SEG_W-1:0]   segment_count;
  logic [bli_pkg::POINT_W-1:0] tick_point [bli_pkg::NUM_POINTS];

  logic signed [bli_pkg::VAL_W-1:0] val;
  logic signed [bli_pkg::VAL_W-1:0] v0;
  logic [bli_pkg::SEG_W-1:0]        s0;
  logic [bli_pkg::TIDX_W-1:0]       x;
  logic [bli_pkg::DEN_W-1:0]        num;
  logic [bli_pkg::DEN_W-1:0]        den;
  logic [bli_pkg::SEG_W-1:0]        abs_ds;
  logic                             ds_neg;
  logic [bli_pkg::DIV_W-1:0]        dvd;
  logic [bli_pkg::LEVEL_W-1:0]      level;
  logic [bli_pkg::PART_W-1:0]       part;
  logic [bli_pkg::IDX_W-1:0]        seg;

  logic [bli_pkg::TCNT_W-1:0]       nticks;
  logic [bli_pkg::SEG_W-1:0]        total;
  logic [bli_pkg::POINT_W-1:0]      cur_point;
  logic signed [bli_pkg::VAL_W-1:0] cur_val;
  logic [bli_pkg::SEG_W-1:0]        cur_seg;
  logic signed [bli_pkg::SEG_W:0]   ds;
  logic [bli_pkg::LEVEL_W-1:0]      level_whole;
  logic [bli_pkg::DIV_W-1:0]        rem_scaled;
  logic [31:0]                      part_prod;
  logic [bli_pkg::LEVEL_W-1:0]      seg_ext;
  bli_pkg::kind_t                   kind;

  logic                        div_busy;
  logic [bli_pkg::QUO_W-1:0]   div_quo;
  logic [bli_pkg::DEN_W-1:0]   div_rem;
  logic [bli_pkg::DEN_W-1:0]   div_divisor;
  logic [bli_pkg::STEPS_W-1:0] div_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      segment_count <= 6'd32;
      for (int k = 0; k < bli_pkg::NUM_POINTS; k++) begin
        tick_point[k] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == bli_pkg::REG_TICK_COUNT) begin
        tick_count <= cfg_data[bli_pkg::TCNT_W-1:0];
      end
      if (cfg_index == bli_pkg::REG_SEGMENT_COUNT) begin
        segment_count <= cfg_data[bli_pkg::SEG_W-1:0];
      end
      for (int k = 0; k < bli_pkg::NUM_POINTS; k++) begin
        if (cfg_index == bli_pkg::CIDX_W'(bli_pkg::REG_TICK_POINT_A + k)) begin
          tick_point[k] <= cfg_data[bli_pkg::POINT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    nticks = (tick_count > bli_pkg::TCNT_W'(MAX_TICKS)) ? bli_pkg::TCNT_W'(MAX_TICKS)
                                                          : tick_count;
    if (segment_count == '0) begin
      total = 6'd1;
    end else if (segment_count > bli_pkg::SEG_W'(MAX_SEGMENTS)) begin
      total = bli_pkg::SEG_W'(MAX_SEGMENTS);
    end else begin
      total = segment_count;
    end
    cur_point = (x < bli_pkg::TIDX_W'(bli_pkg::NUM_POINTS)) ? tick_point[x] : '0;
    cur_val   = cur_point[bli_pkg::VAL_W-1:0];
    cur_seg   = cur_point[bli_pkg::POINT_W-1:bli_pkg::VAL_W];
    ds        = $signed({1'b0, cur_seg}) - $signed({1'b0, s0});
    level_whole = ds_neg ? (bli_pkg::LEVEL_W'(s0) + 7'd1 - bli_pkg::LEVEL_W'(div_quo[5:0]))
                         : (bli_pkg::LEVEL_W'(s0) + 7'd1 + bli_pkg::LEVEL_W'(div_quo[5:0]));
    rem_scaled = ({8'b0, div_rem} << 8) - ({8'b0, div_rem} << 2);
    // The squared fraction is divided by 252 through a reciprocal multiplication.
    part_prod  = 32'(dvd[15:0]) * 32'(bli_pkg::SQ_RECIP);
    seg_ext    = bli_pkg::LEVEL_W'(seg);
    if (seg_ext < level) begin
      kind = bli_pkg::KIND_FULL;
    end else if (seg_ext == level) begin
      kind = bli_pkg::KIND_PARTIAL;
    end else begin
      kind = bli_pkg::KIND_OFF;
    end
    unique case (cmd.div_sel)
      bli_pkg::DIV_WHOLE: begin
        div_divisor = den;
        div_steps   = bli_pkg::STEPS_WHOLE;
      end
      bli_pkg::DIV_FRAC: begin
        div_divisor = den;
        div_steps   = bli_pkg::STEPS_FRAC;
      end
      default: begin
        div_divisor = den;
        div_steps   = bli_pkg::STEPS_WHOLE;
      end
    endcase
  end

  bli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      val <= level_value;
      x   <= '0;
      seg <= '0;
    end
    if (cmd.search_step) begin
      v0 <= cur_val;
      s0 <= cur_seg;
      x  <= x + 1'b1;
    end
    if (cmd.set_below) begin
      level <= '0;
      part  <= '0;
    end
    if (cmd.set_above) begin
      level <= bli_pkg::LEVEL_W'(total);
      part  <= '0;
    end
    if (cmd.take_pair) begin
      num    <= bli_pkg::DEN_W'(val - v0);
      den    <= bli_pkg::DEN_W'(cur_val - v0);
      ds_neg <= ds[bli_pkg::SEG_W];
      abs_ds <= ds[bli_pkg::SEG_W] ? bli_pkg::SEG_W'(-ds) : ds[bli_pkg::SEG_W-1:0];
    end
    if (cmd.mul) begin
      dvd <= bli_pkg::DIV_W'(abs_ds * num);
    end
    if (cmd.take_whole) begin
      level <= level_whole;
      dvd   <= rem_scaled;
    end
    if (cmd.take_frac) begin
      dvd <= bli_pkg::DIV_W'(div_quo * div_quo);
    end
    if (cmd.take_part) begin
      part <= bli_pkg::PART_W'(part_prod >> bli_pkg::SQ_SHIFT);
    end
    if (cmd.emit) begin
      seg <= seg + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      segment_index <= seg;
      segment_kind  <= kind;
      partial_level <= (kind == bli_pkg::KIND_PARTIAL) ? part : '0;
      last_segment  <= (bli_pkg::SEG_W'(seg) == total - 1'b1);
    end
  end

  always_comb begin
    sts.x_zero     = (x == '0);
    sts.at_end     = (x == nticks);
    sts.below_tick = (val < cur_val);
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid || !out_stall;
    sts.last_index = (bli_pkg::SEG_W'(seg) == total - 1'b1);
  end

endmodule

`default_nettype wire

// File: design/bar_level_interpolator.sv
// Top level of the bar level interpolator: controller plus datapath.
// Depends on bli_pkg, bli_ctrl, bli_dpath and bli_div.
//
//   Channel   Direction  Handshake           Payload
//   input     in         in_valid/in_stall   level_value
//   output    out        out_valid/out_stall segment_index, segment_kind,
//                                            partial_level, last_segment
//   config    in         cfg_write           cfg_index, cfg_data
//
// One value is taken at a time; the next is accepted after its last result is loaded.
// The tick search steps through the breakpoints in order; a value inside the table then
// goes through the multiply, the whole-level and fraction divider passes and the squaring
// of the fraction before its segments are emitted in turn, while a value outside the table
// goes straight to emitting its segments. Output stalls lengthen this sequence.
// Reset is synchronous; it restores the state, the divider busy flag, out_valid and the config registers.
// A stalled output holds its transfer; no result is lost.
`timescale 1ns / 1ps
`default_nettype none

module bar_level_interpolator #(
  parameter int MAX_TICKS    = bli_pkg::DEF_MAX_TICKS,
  parameter int MAX_SEGMENTS = bli_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bli_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [bli_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic signed [bli_pkg::VAL_W-1:0]  level_value,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [bli_pkg::IDX_W-1:0]         segment_index,
  output      logic [bli_pkg::KIND_W-1:0]        segment_kind,
  output      logic [bli_pkg::PART_W-1:0]        partial_level,
  output      logic                              last_segment
);

  bli_pkg::cmd_t    cmd;
  bli_pkg::status_t sts;

  bli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bli_dpath #(
    .MAX_TICKS    (MAX_TICKS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .level_value   (level_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .segment_index (segment_index),
    .segment_kind  (segment_kind),
    .partial_level (partial_level),
    .last_segment  (last_segment)
  );

endmodule

`default_nettype wire
